// File: rtl/core/mrfe_pkg.sv
// Package for the matrix rotate/flip engine: transaction structs, operation
// codes, sequencer states and default sizes.
// No dependencies.
package mrfe_pkg;

    localparam int MAX_DIM_DEF    = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic MODE_ROTATE = 1'b0;
    localparam logic MODE_FLIP   = 1'b1;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
        logic               mode;
    } src_item_t;

    typedef struct packed {
        logic signed [31:0] element;
        logic [4:0]         result_rows;
        logic [4:0]         result_cols;
        logic               out_of_range;
    } res_item_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLIP,
        S_TURN,
        S_FETCH,
        S_DONE
    } seq_state_t;

endpackage

// File: rtl/core/matrix_rotate_flip_engine_top.sv
// Top level of the matrix rotate/flip engine: configuration registers,
// composed transform state, sequencer and element store.
// Depends on mrfe_pkg, mrfe_ctrl and mrfe_store.

// Load, push-mode and clear transactions leave the sequencer idle, so the
// engine can take the next one in the following cycle. An in-bounds read
// transaction goes through these steps before the engine is free again:
// latch the position, undo a pending top-bottom flip, undo each stored
// anticlockwise quarter turn (0 to 3), all through one shared mirror
// subtractor, read the store and load the result register. An out-of-bounds
// read skips the mapping and the store and only loads the result register.
// The last step is held for as long as the previous result is still stalled
// at the output. Pushed modes are folded at once into a turn count and a flip
// bit, so the stored matrix is never moved. The store has no reset; reading
// a position never loaded gives an undefined element.
// Configuration writes are always ready and must only be issued while idle.
module matrix_rotate_flip_engine_top
    import mrfe_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  src_item_t  src_item,
    output logic       res_valid,
    input  logic       res_stall,
    output res_item_t  res_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data
);

    logic [4:0] row_count_reg, row_count_next;
    logic [4:0] col_count_reg, col_count_next;
    logic [1:0] turns_reg, turns_next;
    logic       flipped_reg, flipped_next;

    logic                  src_accept;
    logic                  busy;
    store_ctl_t            store_ctl;
    logic [3:0]            rd_row;
    logic [3:0]            rd_col;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [4:0]            cfg_clamped;

    assign cfg_ready  = 1'b1;
    assign src_stall  = busy;
    assign src_accept = src_valid && !src_stall;

    // zero counts as one, anything above MAX_DIM as MAX_DIM
    always_comb
    begin
        if (cfg_data == 5'd0)
            cfg_clamped = 5'd1;
        else if (32'(cfg_data) > 32'(MAX_DIM))
            cfg_clamped = 5'(MAX_DIM);
        else
            cfg_clamped = cfg_data;
    end

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        turns_next     = turns_reg;
        flipped_next   = flipped_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT: row_count_next = cfg_clamped;
                CFG_COL_COUNT: col_count_next = cfg_clamped;
                default:       row_count_next = row_count_reg;
            endcase
        end

        if (src_accept)
        begin
            case (op_t'(src_item.operation))
                OP_PUSH:
                begin
                    // a flip applied first turns later rotations the other way
                    if (src_item.mode == MODE_FLIP)
                    begin
                        flipped_next = !flipped_reg;
                        turns_next   = 2'd0 - turns_reg;
                    end
                    else
                    begin
                        turns_next = turns_reg + 2'd1;
                    end
                end
                OP_CLEAR:
                begin
                    turns_next   = 2'd0;
                    flipped_next = 1'b0;
                end
                default:
                begin
                    flipped_next = flipped_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= 5'd1;
            col_count_reg <= 5'd1;
            turns_reg     <= 2'd0;
            flipped_reg   <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            turns_reg     <= turns_next;
            flipped_reg   <= flipped_next;
        end
    end

    mrfe_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_accept    (src_accept),
        .src_item      (src_item),
        .row_count     (row_count_reg),
        .col_count     (col_count_reg),
        .quarter_turns (turns_reg),
        .flipped       (flipped_reg),
        .res_stall     (res_stall),
        .rd_data       (rd_data),
        .busy          (busy),
        .store_ctl     (store_ctl),
        .rd_row        (rd_row),
        .rd_col        (rd_col),
        .res_valid     (res_valid),
        .res_item      (res_item)
    );

    mrfe_store #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .ctl     (store_ctl),
        .wr_row  (src_item.row),
        .wr_col  (src_item.col),
        .wr_data (DATA_WIDTH'(unsigned'(src_item.value))),
        .rd_row  (rd_row),
        .rd_col  (rd_col),
        .rd_data (rd_data)
    );

endmodule

// File: rtl/core/mrfe_store.sv
// Element store: MAX_DIM x MAX_DIM words, one write and one registered read
// port. Depends on mrfe_pkg.
module mrfe_store
    import mrfe_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  store_ctl_t            ctl,
    input  logic [3:0]            wr_row,
    input  logic [3:0]            wr_col,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [3:0]            rd_row,
    input  logic [3:0]            rd_col,
    output logic [DATA_WIDTH-1:0] rd_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [31:0]           wr_lin;
    logic [31:0]           rd_lin;
    logic                  wr_in_bounds;

    // row-major linear address, row * MAX_DIM + col
    assign wr_lin = 32'(wr_row) * 32'(MAX_DIM) + 32'(wr_col);
    assign rd_lin = 32'(rd_row) * 32'(MAX_DIM) + 32'(rd_col);

    // loads beyond the array are dropped
    assign wr_in_bounds = (32'(wr_row) < 32'(MAX_DIM)) && (32'(wr_col) < 32'(MAX_DIM));

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && wr_in_bounds)
        begin
            mem[wr_lin[ADDR_W-1:0]] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_lin[ADDR_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/mrfe_ctrl.sv
// Read sequencer: maps a transformed position back to the stored matrix by
// undoing a pending flip, then one quarter turn per cycle, through a shared
// mirror subtractor, then fetches. Depends on mrfe_pkg.
module mrfe_ctrl
    import mrfe_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_accept,
    input  src_item_t             src_item,
    input  logic [4:0]            row_count,
    input  logic [4:0]            col_count,
    input  logic [1:0]            quarter_turns,
    input  logic                  flipped,
    input  logic                  res_stall,
    input  logic [DATA_WIDTH-1:0] rd_data,
    output logic                  busy,
    output store_ctl_t            store_ctl,
    output logic [3:0]            rd_row,
    output logic [3:0]            rd_col,
    output logic                  res_valid,
    output res_item_t             res_item
);

    seq_state_t state_reg, state_next;

    logic [3:0] r_reg, r_next;
    logic [3:0] c_reg, c_next;
    logic [4:0] h_reg, h_next;
    logic [4:0] w_reg, w_next;
    logic [1:0] turns_reg, turns_next;
    logic [4:0] dim_rows_reg, dim_rows_next;
    logic [4:0] dim_cols_reg, dim_cols_next;
    logic       oor_reg, oor_next;
    logic       res_valid_reg, res_valid_next;
    res_item_t  res_item_reg, res_item_next;

    logic [4:0]  h_init, w_init;
    logic        oor_init;
    logic [3:0]  mirror;
    logic [63:0] data_wide;

    // current transformed dimensions: odd turn count swaps them
    assign h_init   = quarter_turns[0] ? col_count : row_count;
    assign w_init   = quarter_turns[0] ? row_count : col_count;
    assign oor_init = ({1'b0, src_item.row} >= h_init) || ({1'b0, src_item.col} >= w_init);

    // shared unit: h - 1 - r, used by both the flip and each quarter turn
    assign mirror = 4'(h_reg - 5'd1 - {1'b0, r_reg});

    assign data_wide = 64'(rd_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        c_reg        <= c_next;
        h_reg        <= h_next;
        w_reg        <= w_next;
        turns_reg    <= turns_next;
        dim_rows_reg <= dim_rows_next;
        dim_cols_reg <= dim_cols_next;
        oor_reg      <= oor_next;
        res_item_reg <= res_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        turns_next     = turns_reg;
        dim_rows_next  = dim_rows_reg;
        dim_cols_next  = dim_cols_reg;
        oor_next       = oor_reg;
        res_item_next  = res_item_reg;
        res_valid_next = res_valid_reg && res_stall;
        store_ctl      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (src_accept)
                begin
                    store_ctl.wr_en = (op_t'(src_item.operation) == OP_LOAD);
                    if (op_t'(src_item.operation) == OP_READ)
                    begin
                        r_next        = src_item.row;
                        c_next        = src_item.col;
                        h_next        = h_init;
                        w_next        = w_init;
                        turns_next    = quarter_turns;
                        dim_rows_next = h_init;
                        dim_cols_next = w_init;
                        oor_next      = oor_init;
                        if (oor_init)
                            state_next = S_DONE;
                        else if (flipped)
                            state_next = S_FLIP;
                        else if (quarter_turns != 2'd0)
                            state_next = S_TURN;
                        else
                            state_next = S_FETCH;
                    end
                end
            end
            S_FLIP:
            begin
                r_next     = mirror;
                state_next = (turns_reg != 2'd0) ? S_TURN : S_FETCH;
            end
            S_TURN:
            begin
                // undo one anticlockwise turn: (r, c) came from (c, h-1-r)
                r_next     = c_reg;
                c_next     = mirror;
                h_next     = w_reg;
                w_next     = h_reg;
                turns_next = turns_reg - 2'd1;
                if (turns_reg == 2'd1)
                    state_next = S_FETCH;
            end
            S_FETCH:
            begin
                store_ctl.rd_en = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_item_next.element      = oor_reg ? 32'sd0 : $signed(data_wide[31:0]);
                    res_item_next.result_rows  = dim_rows_reg;
                    res_item_next.result_cols  = dim_cols_reg;
                    res_item_next.out_of_range = oor_reg;
                    res_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign rd_row    = r_reg;
    assign rd_col    = c_reg;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

// File: tb/tb_matrix_rotate_flip_engine_top.sv
// Testbench for matrix_rotate_flip_engine_top: directed and random transactions,
// with every read checked against an in-bench model of the composed transform.
// Depends on mrfe_pkg and the engine RTL.
module tb_matrix_rotate_flip_engine_top;
    import mrfe_pkg::*;

    localparam int DIM           = MAX_DIM_DEF;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 110;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_stall;
    src_item_t  src_item  = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_item_t  res_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = CFG_ROW_COUNT;
    logic [4:0] cfg_data  = 5'd1;

    matrix_rotate_flip_engine_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Model of the engine: original matrix plus composed transform
    logic signed [31:0] matrix_mem [DIM*DIM];
    bit                 loaded     [DIM*DIM];
    logic [1:0]         turns      = 2'd0;
    logic               flip_bit   = 1'b0;
    int                 rows_cfg   = 1;
    int                 cols_cfg   = 1;
    res_item_t          pending_reads [$];

    int err_count   = 0;
    int idle_cycles = 0;
    bit gaps_on     = 1'b1;
    int burst_left  = 0;
    int hold_gen    = 0;
    int hold_done   = 0;
    int hold_left   = 0;
    int stall_style = 0;
    int style_left  = 0;

    function automatic int clamp_dim(input logic [4:0] v);
        if (v == 5'd0)
            return 1;
        if (v > DIM)
            return DIM;
        return int'(v);
    endfunction

    function automatic int view_rows();
        return turns[0] ? cols_cfg : rows_cfg;
    endfunction

    function automatic int view_cols();
        return turns[0] ? rows_cfg : cols_cfg;
    endfunction

    // Original-matrix slot that a read of (r, c) lands on; -1 when out of bounds
    function automatic int source_slot(input int r, input int c);
        int h, w, t, k, rr, cc;
        h  = view_rows();
        w  = view_cols();
        rr = r;
        cc = c;
        if (rr >= h || cc >= w)
            return -1;
        if (flip_bit)
            rr = h - 1 - rr;
        // undo one anticlockwise turn per step, newest first
        for (k = 0; k < int'(turns); k++)
        begin
            t  = rr;
            rr = cc;
            cc = h - 1 - t;
            t  = h;
            h  = w;
            w  = t;
        end
        return rr * DIM + cc;
    endfunction

    function automatic res_item_t predict_read(input logic [3:0] r, input logic [3:0] c);
        res_item_t exp_item;
        int        slot;
        slot                  = source_slot(r, c);
        exp_item.result_rows  = 5'(view_rows());
        exp_item.result_cols  = 5'(view_cols());
        exp_item.out_of_range = (slot < 0);
        exp_item.element      = (slot < 0) ? 32'sd0 : matrix_mem[slot];
        return exp_item;
    endfunction

    function automatic void advance_model(input src_item_t it);
        case (it.operation)
            OP_LOAD:
            begin
                matrix_mem[it.row * DIM + it.col] = it.value;
                loaded[it.row * DIM + it.col]     = 1'b1;
            end
            OP_PUSH:
            begin
                if (it.mode == MODE_ROTATE)
                    turns = turns + 2'd1;
                else
                begin
                    // flip after the turns equals flip before the inverse turns
                    flip_bit = ~flip_bit;
                    turns    = 2'd0 - turns;
                end
            end
            OP_CLEAR:
            begin
                turns    = 2'd0;
                flip_bit = 1'b0;
            end
            default:
                pending_reads.push_back(predict_read(it.row, it.col));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic src_item_t rand_fill(input op_t op);
        src_item_t it;
        it.operation = op;
        it.row       = 4'($urandom());
        it.col       = 4'($urandom());
        it.value     = rand_value();
        it.mode      = 1'($urandom());
        return it;
    endfunction

    function automatic void report_mismatch(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("mismatch: %s", msg);
    endfunction

    // Offers one transaction and returns once it has been taken; valid stays high
    task automatic send_item(input src_item_t it);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                src_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        src_valid <= 1'b1;
        src_item  <= it;
        do @(posedge clk); while (src_stall);
        advance_model(it);
    endtask

    task automatic load_at(input int r, input int c, input logic signed [31:0] v);
        src_item_t it;
        it       = rand_fill(OP_LOAD);
        it.row   = 4'(r);
        it.col   = 4'(c);
        it.value = v;
        send_item(it);
    endtask

    task automatic push_mode(input logic m);
        src_item_t it;
        it      = rand_fill(OP_PUSH);
        it.mode = m;
        send_item(it);
    endtask

    task automatic clear_modes();
        send_item(rand_fill(OP_CLEAR));
    endtask

    // Reads a position, loading its source element first if it was never written
    task automatic read_at(input int r, input int c);
        src_item_t it;
        int        slot;
        slot = source_slot(r, c);
        if (slot >= 0 && !loaded[slot])
            load_at(slot / DIM, slot % DIM, rand_value());
        it     = rand_fill(OP_READ);
        it.row = 4'(r);
        it.col = 4'(c);
        send_item(it);
    endtask

    // Sender goes quiet until every outstanding read has been answered
    task automatic wait_drained();
        @(negedge clk);
        src_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_ROW_COUNT)
            rows_cfg = clamp_dim(data);
        else
            cols_cfg = clamp_dim(data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(input logic [4:0] rows_code, input logic [4:0] cols_code);
        wait_drained();
        write_reg(CFG_ROW_COUNT, rows_code);
        write_reg(CFG_COL_COUNT, cols_code);
    endtask

    function automatic logic [4:0] pick_dim_code();
        int p;
        p = $urandom_range(0, 9);
        case (p)
            0:       return 5'd0;
            1:       return 5'd16;
            2:       return 5'd31;
            3:       return 5'($urandom_range(7, 31));
            default: return 5'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic random_step();
        src_item_t it;
        int        p;
        p  = $urandom_range(0, 99);
        it = rand_fill(OP_LOAD);
        if (p < 25)
        begin
            // mostly inside the configured size, now and then anywhere
            if ($urandom_range(0, 4) != 0)
            begin
                it.row = 4'($urandom_range(0, rows_cfg - 1));
                it.col = 4'($urandom_range(0, cols_cfg - 1));
            end
            send_item(it);
        end
        else if (p < 42)
        begin
            it.operation = OP_PUSH;
            send_item(it);
        end
        else if (p < 46)
        begin
            it.operation = OP_CLEAR;
            send_item(it);
        end
        else if ($urandom_range(0, 6) != 0)
            read_at($urandom_range(0, view_rows() - 1), $urandom_range(0, view_cols() - 1));
        else
            read_at(it.row, it.col);
    endtask

    task automatic test_after_reset();
        read_at(15, 15);
        read_at(0, 1);
        read_at(1, 0);
        read_at(0, 0);
    endtask

    task automatic test_corners();
        set_size(5'd31, 5'd16);
        load_at(0, 0, 32'sh8000_0000);
        load_at(0, 15, 32'sh7fff_ffff);
        load_at(15, 0, -32'sd1);
        load_at(15, 15, 32'sd0);
        read_at(0, 0);
        read_at(0, 15);
        read_at(15, 0);
        read_at(15, 15);
        push_mode(MODE_ROTATE);
        read_at(0, 0);
        read_at(15, 15);
        push_mode(MODE_FLIP);
        read_at(0, 15);
        clear_modes();
        read_at(15, 0);
    endtask

    task automatic test_mode_order();
        // zero row count clamps to one row
        set_size(5'd0, 5'd5);
        read_at(0, 4);
        push_mode(MODE_ROTATE);
        read_at(4, 0);
        read_at(0, 1);
        push_mode(MODE_FLIP);
        read_at(0, 0);
        read_at(15, 15);
    endtask

    task automatic test_random_phases();
        int ph, n, r, c;
        for (ph = 0; ph < PHASES; ph++)
        begin
            // modes are kept across the resize on purpose
            set_size(pick_dim_code(), pick_dim_code());
            if (rows_cfg * cols_cfg <= 40 && $urandom_range(0, 1) == 1)
                for (r = 0; r < rows_cfg; r++)
                    for (c = 0; c < cols_cfg; c++)
                        load_at(r, c, rand_value());
            for (n = 0; n < PHASE_ITEMS; n++)
                random_step();
        end
    endtask

    task automatic test_backpressure();
        int n;
        wait_drained();
        gaps_on = 1'b0;
        hold_gen++;
        for (n = 0; n < 50; n++)
            random_step();
        gaps_on = 1'b1;
    endtask

    task automatic test_pause_for_results();
        int n;
        for (n = 0; n < 20; n++)
            random_step();
        wait_drained();
        for (n = 0; n < 20; n++)
            random_step();
    endtask

    // Receiver stall pattern, with an occasional long hold-off on request
    always @(negedge clk)
    begin
        if (hold_done != hold_gen)
        begin
            hold_done = hold_gen;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(10, 80);
            end
            style_left--;
            case (stall_style)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                2:       res_stall <= ($urandom_range(0, 3) != 0);
                default: res_stall <= style_left[2];
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        res_item_t exp_item;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_reads.size() == 0)
                report_mismatch($sformatf("result with no read outstanding: element %0d rows %0d cols %0d oor %0b",
                    res_item.element, res_item.result_rows, res_item.result_cols,
                    res_item.out_of_range));
            else
            begin
                exp_item = pending_reads.pop_front();
                if (res_item.element !== exp_item.element
                    || res_item.result_rows !== exp_item.result_rows
                    || res_item.result_cols !== exp_item.result_cols
                    || res_item.out_of_range !== exp_item.out_of_range)
                    report_mismatch($sformatf(
                        "expected element %0d rows %0d cols %0d oor %0b, got element %0d rows %0d cols %0d oor %0b",
                        exp_item.element, exp_item.result_rows, exp_item.result_cols,
                        exp_item.out_of_range, res_item.element, res_item.result_rows,
                        res_item.result_cols, res_item.out_of_range));
            end
        end
    end

    // Watchdog: any accepted transaction on any channel resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && !src_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** matrix_rotate_flip_engine_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        foreach (loaded[i])
            loaded[i] = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_corners();
        test_mode_order();
        test_random_phases();
        test_backpressure();
        test_pause_for_results();
        wait_drained();

        if (err_count == 0 && pending_reads.size() == 0)
            $display("** matrix_rotate_flip_engine_top: PASSED **");
        else
            $display("** matrix_rotate_flip_engine_top: FAILED **");
        $finish;
    end

endmodule
